// ----- design/crc_checked_record_ring_log_core_macros.svh -----
// assertion macros for the ring log core
// no dependencies
`ifndef CRC_CHECKED_RECORD_RING_LOG_CORE_MACROS_SVH
`define CRC_CHECKED_RECORD_RING_LOG_CORE_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define RRL_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ring log check failed");
// next-cycle implication
`define RRL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ring log check failed");
`endif

// ----- design/rrl_pkg.sv -----
// package for the ring log core: payload structs, codes, crc helper
// no dependencies
package rrl_pkg;

    localparam int MAX_SLOTS_DEF = 256;
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_GET    = 2'd1;
    localparam logic [1:0] MODE_WIPE   = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BAD_SEQ = 3'd1;
    localparam logic [2:0] ST_EVICTED = 3'd2;
    localparam logic [2:0] ST_BAD_CRC = 3'd3;
    localparam logic [2:0] ST_SEQ_MIS = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] seq_query;
        logic [31:0] start_time;
        logic [31:0] duration;
        logic [63:0] dist_mm;
        logic [15:0] avg_rpm;
        logic [15:0] max_rpm;
        logic [7:0]  basis_code;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] seq_out;
        logic [31:0] epoch_out;
        logic [31:0] elapsed_out;
        logic [63:0] dist_out;
        logic [15:0] avg_rpm_out;
        logic [15:0] max_rpm_out;
        logic [7:0]  basis_out;
        logic [8:0]  valid_slots;
        logic [8:0]  free_slots;
    } out_item_t;

    // one byte through the reflected crc, eight bit steps
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
        end
        return r;
    endfunction

endpackage

// ----- design/rrl_crc_unit.sv -----
// crc-32 over one 64-bit word, one byte per cycle; lanes limited by byte count
// depends on rrl_pkg
module rrl_crc_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic        init,
    input  logic [63:0] word,
    input  logic [3:0]  nbytes,
    output logic        busy,
    output logic [31:0] crc
);
    logic [31:0] crc_reg, crc_next;
    logic [63:0] sh_reg, sh_next;
    logic [3:0]  cnt_reg, cnt_next;

    // byte shifter
    always_comb begin
        crc_next = crc_reg;
        sh_next  = sh_reg;
        cnt_next = cnt_reg;
        if (start) begin
            crc_next = init ? rrl_pkg::CRC_INIT : crc_reg;
            sh_next  = word;
            cnt_next = nbytes;
        end else if (cnt_reg != 4'd0) begin
            crc_next = rrl_pkg::crc_byte(crc_reg, sh_reg[7:0]);
            sh_next  = sh_reg >> 8;
            cnt_next = cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 4'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        crc_reg <= crc_next;
        sh_reg  <= sh_next;
    end

    assign busy = (cnt_reg != 4'd0);
    assign crc  = crc_reg ^ rrl_pkg::CRC_INIT;
endmodule

// ----- design/crc_checked_record_ring_log_core.sv -----
// ring log of crc-checked records, 32-byte slots as four 64-bit memory words
// append, or a get that reaches a slot: m_valid once the crc has run over the slot, through
// S_WR, S_CRC and S_OUT or S_RD and S_OUT (crc passes over 8, 8, 8 and 4 bytes)
// bad sequence, evicted, wipe and unused mode: straight from idle to S_OUT, which raises m_valid
// one transaction at a time: the next is taken only after the result is accepted
// synchronous active-low reset: next sequence 1, counts and head 0, slot count 256
module crc_checked_record_ring_log_core #(
    parameter int MAX_SLOTS = rrl_pkg::MAX_SLOTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [8:0]           cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rrl_pkg::in_item_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rrl_pkg::out_item_t   m_data
);
`include "crc_checked_record_ring_log_core_macros.svh"

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int AW = IW + 2;
    localparam int CW = $clog2(MAX_SLOTS + 1);

    typedef enum logic [2:0] {S_IDLE, S_WR, S_RD, S_CRC, S_OUT} state_t;
    state_t state_reg;

    logic [63:0] mem [0:4*MAX_SLOTS-1];
    logic [63:0] rdata_reg;
    logic [AW-1:0] raddr;
    logic        mem_we;
    logic [AW-1:0] waddr;
    logic [63:0] wdata;

    logic [8:0]    slot_cfg_reg;
    logic [31:0]   next_seq_reg;
    logic [CW-1:0] fill_reg;
    logic [IW-1:0] head_reg;
    logic [CW-1:0] eff;

    logic [31:0] query_reg;
    rrl_pkg::out_item_t out_reg;
    logic [63:0] w_reg [0:3];
    logic [2:0]  wc_reg;
    logic        rd_pend_reg;
    logic [IW-1:0] slot_reg;
    logic        crc_start;
    logic        crc_init;
    logic [63:0] crc_word;
    logic [3:0]  crc_nb;
    logic        crc_busy;
    logic [31:0] crc_val;

    // effective slot count, clamped
    always_comb begin
        if (slot_cfg_reg == 9'd0) begin
            eff = CW'(1);
        end else if (32'(slot_cfg_reg) > 32'(MAX_SLOTS)) begin
            eff = CW'(MAX_SLOTS);
        end else begin
            eff = CW'(slot_cfg_reg);
        end
    end

    // memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    rrl_crc_unit u_crc (
        .aclk(aclk), .aresetn(aresetn), .start(crc_start), .init(crc_init),
        .word(crc_word), .nbytes(crc_nb), .busy(crc_busy), .crc(crc_val)
    );

    // age and slot of a query
    logic [31:0] age;
    logic [IW-1:0] qslot;
    logic [CW:0] qtmp;
    always_comb begin
        age  = next_seq_reg - 32'd1 - s_data.seq_query;
        qtmp = {1'b0, CW'(head_reg)} + {1'b0, eff} - (CW+1)'(1) - (CW+1)'(age[CW-1:0]);
        if (qtmp >= {1'b0, eff}) begin
            qtmp = qtmp - {1'b0, eff};
        end
        qslot = qtmp[IW-1:0];
    end

    logic [CW-1:0] free_now;
    assign free_now = (fill_reg >= eff) ? CW'(0) : eff - fill_reg;

    logic bad_seq;
    logic evicted;
    assign bad_seq = (s_data.seq_query == 32'd0) || (s_data.seq_query >= next_seq_reg);
    assign evicted = (age >= 32'(fill_reg));

    // result fields known when the input transaction is taken
    rrl_pkg::out_item_t idle_out;
    always_comb begin
        idle_out = '0;
        case (s_data.mode)
            rrl_pkg::MODE_APPEND: begin
                idle_out.seq_out = next_seq_reg;
            end
            rrl_pkg::MODE_GET: begin
                idle_out.valid_slots = 9'(fill_reg);
                idle_out.free_slots  = 9'(free_now);
                if (bad_seq) begin
                    idle_out.status = rrl_pkg::ST_BAD_SEQ;
                end else if (evicted) begin
                    idle_out.status = rrl_pkg::ST_EVICTED;
                end
            end
            rrl_pkg::MODE_WIPE: begin
                idle_out.free_slots = 9'(eff);
            end
            default: begin
                idle_out.valid_slots = 9'(fill_reg);
                idle_out.free_slots  = 9'(free_now);
            end
        endcase
    end

    // word 0 of a queried slot is addressed while idle, ready on the first read cycle
    assign s_ready  = (state_reg == S_IDLE) && !m_valid && !cfg_we;
    assign raddr    = (state_reg == S_IDLE) ? {qslot, 2'b00} : {slot_reg, wc_reg[1:0]};
    assign crc_word = (state_reg == S_WR) ? w_reg[wc_reg[1:0]] : rdata_reg;
    assign crc_nb   = (wc_reg[1:0] == 2'd3) ? 4'd4 : 4'd8;
    assign crc_init = (wc_reg[1:0] == 2'd0);
    assign waddr    = {slot_reg, wc_reg[1:0]};

    always_comb begin
        mem_we    = 1'b0;
        wdata     = w_reg[wc_reg[1:0]];
        crc_start = 1'b0;
        if (state_reg == S_WR && !crc_busy && wc_reg != 3'd4) begin
            crc_start = 1'b1;
        end
        if (state_reg == S_CRC) begin
            mem_we = 1'b1;
            wdata  = {crc_val, w_reg[3][31:0]};
        end
        if (state_reg == S_RD && rd_pend_reg && wc_reg != 3'd4 && !crc_busy) begin
            crc_start = 1'b1;
        end
        if (state_reg == S_WR && !crc_busy && wc_reg != 3'd4 && wc_reg != 3'd3) begin
            mem_we = 1'b1;
        end
    end

    // control and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_valid      <= 1'b0;
            slot_cfg_reg <= 9'd256;
            next_seq_reg <= 32'd1;
            fill_reg     <= '0;
            head_reg     <= '0;
            wc_reg       <= '0;
            rd_pend_reg  <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
            if (cfg_we) begin
                slot_cfg_reg <= cfg_wdata;
                fill_reg     <= '0;
                head_reg     <= '0;
            end else begin
                case (state_reg)
                    S_IDLE: begin
                        if (s_valid && s_ready) begin
                            query_reg <= s_data.seq_query;
                            out_reg   <= idle_out;
                            wc_reg    <= '0;
                            case (s_data.mode)
                                rrl_pkg::MODE_APPEND: begin
                                    slot_reg <= head_reg;
                                    w_reg[0] <= {s_data.start_time, next_seq_reg};
                                    w_reg[1] <= {s_data.dist_mm[31:0], s_data.duration};
                                    w_reg[2] <= {s_data.max_rpm, s_data.avg_rpm,
                                                 s_data.dist_mm[63:32]};
                                    w_reg[3] <= {32'd0, 24'd0, s_data.basis_code};
                                    next_seq_reg <= next_seq_reg + 32'd1;
                                    state_reg <= S_WR;
                                end
                                rrl_pkg::MODE_GET: begin
                                    if (bad_seq || evicted) begin
                                        state_reg <= S_OUT;
                                    end else begin
                                        slot_reg    <= qslot;
                                        rd_pend_reg <= 1'b1;
                                        state_reg   <= S_RD;
                                    end
                                end
                                rrl_pkg::MODE_WIPE: begin
                                    fill_reg  <= '0;
                                    head_reg  <= '0;
                                    state_reg <= S_OUT;
                                end
                                default: begin
                                    state_reg <= S_OUT;
                                end
                            endcase
                        end
                    end
                    S_WR: begin
                        // words 0..2 written while the crc runs; word 3 after
                        if (!crc_busy) begin
                            if (wc_reg == 3'd4) begin
                                state_reg <= S_CRC;
                                wc_reg    <= 3'd3;
                            end else begin
                                wc_reg <= wc_reg + 3'd1;
                            end
                        end
                    end
                    S_CRC: begin
                        if (fill_reg < eff) begin
                            fill_reg <= fill_reg + CW'(1);
                            out_reg.valid_slots <= 9'(fill_reg + CW'(1));
                            out_reg.free_slots  <= 9'(eff - fill_reg - CW'(1));
                        end else begin
                            out_reg.valid_slots <= 9'(fill_reg);
                            out_reg.free_slots  <= 9'd0;
                        end
                        if (CW'(head_reg) + CW'(1) >= eff) begin
                            head_reg <= '0;
                        end else begin
                            head_reg <= head_reg + IW'(1);
                        end
                        state_reg <= S_OUT;
                    end
                    S_RD: begin
                        // read word, then feed it to the crc; address held till used
                        if (rd_pend_reg && !crc_busy) begin
                            if (wc_reg == 3'd4) begin
                                rd_pend_reg <= 1'b0;
                            end else begin
                                w_reg[wc_reg[1:0]] <= rdata_reg;
                                wc_reg <= wc_reg + 3'd1;
                            end
                        end
                        if (!rd_pend_reg) begin
                            out_reg.valid_slots <= 9'(fill_reg);
                            out_reg.free_slots  <= 9'(free_now);
                            if (w_reg[3][63:32] != crc_val) begin
                                out_reg.status <= rrl_pkg::ST_BAD_CRC;
                            end else begin
                                out_reg.status <= (w_reg[0][31:0] == query_reg)
                                    ? rrl_pkg::ST_OK : rrl_pkg::ST_SEQ_MIS;
                                out_reg.seq_out     <= w_reg[0][31:0];
                                out_reg.epoch_out   <= w_reg[0][63:32];
                                out_reg.elapsed_out <= w_reg[1][31:0];
                                out_reg.dist_out    <= {w_reg[2][31:0], w_reg[1][63:32]};
                                out_reg.avg_rpm_out <= w_reg[2][47:32];
                                out_reg.max_rpm_out <= w_reg[2][63:48];
                                out_reg.basis_out   <= w_reg[3][7:0];
                            end
                            state_reg <= S_OUT;
                        end
                    end
                    S_OUT: begin
                        m_valid   <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    default: state_reg <= S_IDLE;
                endcase
            end
        end
    end

    assign m_data = out_reg;

    // checks
    `RRL_ASSERT_IMPL(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= eff)
    `RRL_ASSERT_IMPL(a_no_accept_busy, aclk, aresetn, state_reg != S_IDLE, !s_ready)
    `RRL_ASSERT_NEXT(a_out_follows, aclk, aresetn, state_reg == S_OUT, m_valid)

endmodule

// ----- verif/crc_checked_record_ring_log_core_tb.sv -----
// self-checking testbench for the crc-checked ring log core
// depends on rrl_pkg and crc_checked_record_ring_log_core
module crc_checked_record_ring_log_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [8:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    rrl_pkg::in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rrl_pkg::out_item_t m_data;

    // predictor state
    logic [63:0] ring_words [0:rrl_pkg::MAX_SLOTS_DEF*4-1];
    logic [31:0] exp_next_seq;
    int unsigned fill_n, head_n, valid_n, slots_reg;
    rrl_pkg::out_item_t pending_results[$];
    int error_count = 0;
    bit long_hold = 1'b0;
    int unsigned last_seq_issued;

    crc_checked_record_ring_log_core DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int unsigned active_slots();
        if (slots_reg == 0) return 1;
        if (slots_reg > rrl_pkg::MAX_SLOTS_DEF) return rrl_pkg::MAX_SLOTS_DEF;
        return slots_reg;
    endfunction

    // reflected crc-32 over the 28 payload bytes of a slot
    function automatic logic [31:0] record_crc(input logic [63:0] w0, input logic [63:0] w1,
                                               input logic [63:0] w2, input logic [63:0] w3);
        logic [223:0] bytes;
        logic [31:0] c;
        bytes = {w3[31:0], w2, w1, w0};
        c = 32'hFFFFFFFF;
        for (int i = 0; i < 28; i++) begin
            c = c ^ {24'd0, bytes[i*8 +: 8]};
            for (int k = 0; k < 8; k++) c = (c >> 1) ^ (c[0] ? 32'hEDB88320 : 32'd0);
        end
        return ~c;
    endfunction

    // expected result of one transaction, updating the predictor
    function automatic rrl_pkg::out_item_t predict_log_step(input rrl_pkg::in_item_t it);
        rrl_pkg::out_item_t r;
        int unsigned n, base, age, idx;
        logic [63:0] w0, w1, w2, w3;
        r = '0;
        n = active_slots();
        if (it.mode == rrl_pkg::MODE_APPEND) begin
            base = (head_n % n) * 4;
            w0 = {it.start_time, exp_next_seq};
            w1 = {it.dist_mm[31:0], it.duration};
            w2 = {it.max_rpm, it.avg_rpm, it.dist_mm[63:32]};
            w3 = {32'd0, 24'd0, it.basis_code};
            w3[63:32] = record_crc(w0, w1, w2, w3);
            ring_words[base] = w0; ring_words[base+1] = w1;
            ring_words[base+2] = w2; ring_words[base+3] = w3;
            r.seq_out = exp_next_seq;
            last_seq_issued = exp_next_seq;
            exp_next_seq = exp_next_seq + 32'd1;
            if (fill_n < n) begin
                fill_n++;
                valid_n++;
            end
            head_n = (head_n + 1) % n;
        end else if (it.mode == rrl_pkg::MODE_GET) begin
            if (it.seq_query == 32'd0 || it.seq_query >= exp_next_seq) begin
                r.status = rrl_pkg::ST_BAD_SEQ;
            end else begin
                age = exp_next_seq - 32'd1 - it.seq_query;
                if (age >= fill_n) begin
                    r.status = rrl_pkg::ST_EVICTED;
                end else begin
                    idx = ((head_n % n) + n - 1 - age) % n;
                    w0 = ring_words[idx*4]; w1 = ring_words[idx*4+1];
                    w2 = ring_words[idx*4+2]; w3 = ring_words[idx*4+3];
                    if (w3[63:32] != record_crc(w0, w1, w2, w3)) begin
                        r.status = rrl_pkg::ST_BAD_CRC;
                    end else begin
                        r.seq_out = w0[31:0];
                        r.epoch_out = w0[63:32];
                        r.elapsed_out = w1[31:0];
                        r.dist_out = {w2[31:0], w1[63:32]};
                        r.avg_rpm_out = w2[47:32];
                        r.max_rpm_out = w2[63:48];
                        r.basis_out = w3[7:0];
                        r.status = (w0[31:0] == it.seq_query)
                            ? rrl_pkg::ST_OK : rrl_pkg::ST_SEQ_MIS;
                    end
                end
            end
        end else if (it.mode == rrl_pkg::MODE_WIPE) begin
            fill_n = 0; valid_n = 0; head_n = 0;
        end
        r.valid_slots = 9'(valid_n);
        r.free_slots = (fill_n >= n) ? 9'd0 : 9'(n - fill_n);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // send one transaction after a random gap; s_ready only moves at rising
    // edges, so it is steady at the falling edge before the accepting edge
    task automatic send_record(input rrl_pkg::in_item_t it);
        int unsigned gap;
        gap = $urandom_range(0, 16);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        pending_results.push_back(predict_log_step(it));
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
    endtask

    // receiver stall per result, long hold when requested
    initial begin
        int unsigned stall;
        @(posedge aresetn);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (400) @(posedge aclk);
                long_hold = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(negedge aclk);
            while (!m_valid) @(negedge aclk);
            @(posedge aclk);
        end
    end

    // compare every result transaction with the oldest expectation; handshake
    // signals only move at rising edges, so the falling edge shows the
    // transaction that completes at the next rising edge
    always @(negedge aclk) begin
        rrl_pkg::out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result transaction", 64'd0, 64'd0);
            end else begin
                e = pending_results.pop_front();
                if (m_data.status !== e.status)
                    report_mismatch("status", 64'(m_data.status), 64'(e.status));
                if (m_data.seq_out !== e.seq_out)
                    report_mismatch("seq_out", 64'(m_data.seq_out), 64'(e.seq_out));
                if (m_data.epoch_out !== e.epoch_out)
                    report_mismatch("epoch_out", 64'(m_data.epoch_out), 64'(e.epoch_out));
                if (m_data.elapsed_out !== e.elapsed_out)
                    report_mismatch("elapsed_out", 64'(m_data.elapsed_out),
                                    64'(e.elapsed_out));
                if (m_data.dist_out !== e.dist_out)
                    report_mismatch("dist_out", m_data.dist_out, e.dist_out);
                if (m_data.avg_rpm_out !== e.avg_rpm_out)
                    report_mismatch("avg_rpm_out", 64'(m_data.avg_rpm_out),
                                    64'(e.avg_rpm_out));
                if (m_data.max_rpm_out !== e.max_rpm_out)
                    report_mismatch("max_rpm_out", 64'(m_data.max_rpm_out),
                                    64'(e.max_rpm_out));
                if (m_data.basis_out !== e.basis_out)
                    report_mismatch("basis_out", 64'(m_data.basis_out), 64'(e.basis_out));
                if (m_data.valid_slots !== e.valid_slots)
                    report_mismatch("valid_slots", 64'(m_data.valid_slots),
                                    64'(e.valid_slots));
                if (m_data.free_slots !== e.free_slots)
                    report_mismatch("free_slots", 64'(m_data.free_slots),
                                    64'(e.free_slots));
            end
        end
    end

    function automatic rrl_pkg::in_item_t random_record();
        rrl_pkg::in_item_t it;
        it = '0;
        it.mode = rrl_pkg::MODE_APPEND;
        it.seq_query = $urandom;
        it.start_time = $urandom;
        it.duration = $urandom;
        it.dist_mm = {$urandom, $urandom};
        it.avg_rpm = 16'($urandom);
        it.max_rpm = 16'($urandom);
        it.basis_code = 8'($urandom);
        return it;
    endfunction

    function automatic rrl_pkg::in_item_t get_item(input logic [31:0] q);
        rrl_pkg::in_item_t it;
        it = random_record();
        it.mode = rrl_pkg::MODE_GET;
        it.seq_query = q;
        return it;
    endfunction

    // wait until the block is idle, then write the slot count
    task automatic set_slot_count(input logic [8:0] v);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        slots_reg = 32'(v);
        fill_n = 0; valid_n = 0; head_n = 0;
    endtask

    // extremes of every field, each operation, and the ok, bad sequence and evicted statuses
    task automatic test_directed();
        rrl_pkg::in_item_t it;
        send_record(get_item(32'd0));
        send_record(get_item(32'd1));
        it = random_record();
        it.start_time = '1; it.duration = '1; it.dist_mm = '1;
        it.avg_rpm = '1; it.max_rpm = '1; it.basis_code = '1;
        send_record(it);
        it = random_record();
        it.start_time = '0; it.duration = '0; it.dist_mm = '0;
        it.avg_rpm = '0; it.max_rpm = '0; it.basis_code = '0;
        send_record(it);
        send_record(get_item(32'd1));
        send_record(get_item(32'd2));
        send_record(get_item(32'hFFFFFFFF));
        it = random_record(); it.mode = rrl_pkg::MODE_WIPE;
        send_record(it);
        send_record(get_item(32'd2));
        it = random_record(); it.mode = rrl_pkg::MODE_NONE;
        send_record(it);
        send_record(random_record());
        send_record(get_item(last_seq_issued));
    endtask

    // small ring: eviction by wrap, then a zero and an oversized slot count
    task automatic test_wrap();
        set_slot_count(9'd3);
        for (int i = 0; i < 5; i++) send_record(random_record());
        for (int a = 0; a < 5; a++) send_record(get_item(last_seq_issued - a));
        set_slot_count(9'd0);
        send_record(random_record());
        send_record(random_record());
        send_record(get_item(last_seq_issued));
        send_record(get_item(last_seq_issued - 1));
        set_slot_count(9'd511);
        send_record(random_record());
        send_record(get_item(last_seq_issued));
    endtask

    // long receiver hold while the sender keeps offering
    task automatic test_backpressure();
        long_hold = 1'b1;
        for (int i = 0; i < 20; i++) send_record(random_record());
    endtask

    // random mix, mostly appends and gets of recent records
    task automatic test_random(input int count);
        rrl_pkg::in_item_t it;
        int unsigned k;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 99);
            if (k < 45) it = random_record();
            else if (k < 85) it = get_item(last_seq_issued - $urandom_range(0, 12));
            else if (k < 93) it = get_item($urandom);
            else if (k < 97) begin it = random_record(); it.mode = rrl_pkg::MODE_WIPE; end
            else begin it = random_record(); it.mode = rrl_pkg::MODE_NONE; end
            send_record(it);
        end
    endtask

    // test sequence
    initial begin
        exp_next_seq = 32'd1; fill_n = 0; head_n = 0; valid_n = 0;
        slots_reg = 256; last_seq_issued = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_wrap();
        test_backpressure();
        set_slot_count(9'd8);
        test_random(600);
        set_slot_count(9'd1);
        test_random(300);
        set_slot_count(9'd256);
        test_random(700);
        set_slot_count(9'd20);
        test_random(250);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (error_count == 0) $display("crc_checked_record_ring_log_core regression: pass");
        else $display("crc_checked_record_ring_log_core regression: fail");
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("crc_checked_record_ring_log_core regression: fail");
        $finish;
    end
endmodule

// ----- crc_checked_record_ring_log_core.f -----
+incdir+design
design/rrl_pkg.sv
design/rrl_crc_unit.sv
design/crc_checked_record_ring_log_core.sv
verif/crc_checked_record_ring_log_core_tb.sv
